### sv/rsch_pkg.sv
// shared types and constants for the ray closest-hit core
`timescale 1ns / 1ps
package rsch_pkg;

	localparam logic [25:0] LIMIT_Q16 = 26'd65536000;
	localparam logic [2:0]  FLOOR_ID  = 3'd4;
	localparam logic [15:0] UNIT_Q14  = 16'd16384;

	// register indexes on the config port
	localparam logic [2:0] CFG_COUNT = 3'd0;
	localparam logic [2:0] CFG_SPH0  = 3'd1;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic [2:0]         object_id;
		logic               checker_dark;
		logic [25:0]        distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} hit_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SLOAD, ST_DOT, ST_LL, ST_TSQ, ST_RSQ, ST_SQ1, ST_TSEL,
		ST_PNT, ST_VLEN, ST_LSTART, ST_LWAIT, ST_NSTART, ST_NWAIT, ST_NEXT,
		ST_FLOOR, ST_FWAIT, ST_FCHK, ST_FPNT, ST_FEND, ST_DONE
	} state_t;

endpackage

### sv/rsch_isqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module rsch_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);
	logic [63:0] v_q, res_q, bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign busy  = |bit_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			res_q <= '0;
			bit_q <= '0;
		end else if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

### sv/rsch_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsch_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic [47:0] quot
);
	logic [47:0] num_q;
	logic [31:0] rem_q, den_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem2, diff;
	logic        ge;

	assign rem2 = {rem_q, num_q[47]};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};
	assign busy = cnt_q != 6'd0;
	assign quot = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			num_q <= {num_q[46:0], ge};
			rem_q <= ge ? diff[31:0] : rem2[31:0];
		end
	end
endmodule

### sv/ray_scene_closest_hit_core.sv
// ray closest-hit core: spheres and checker floor on one shared multiplier
`timescale 1ns / 1ps
// Finds the nearest hit of one ray against up to MAX_SPHERES spheres and a
// bounded checker floor at y = -4, and returns distance, point, normal, object
// and checker parity. One ray is in flight at a time. An active sphere out of
// range is skipped; else dot products and squares follow and a ray clear of
// it moves on. Else a square root gives the root; a new nearest hit also takes
// the point, a second square root and up to three divides for the normal; the
// floor takes at most one divide. The time is set by the 32-step square root,
// which all spheres share, the 48-step divider, which the spheres and the floor
// share, and by the single 32x32 multiplier. A finished result waits in an
// output register while the next ray is taken in.
module ray_scene_closest_hit_core import rsch_pkg::*; #(
	parameter int MAX_SPHERES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ray_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output hit_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int SW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

	state_t state_q, state_d;

	// config registers
	logic [2:0]  count_q;
	logic [63:0] sph_q [MAX_SPHERES];
	logic [2:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx    = paddr[5:3];
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int s = 0; s < MAX_SPHERES; s++) sph_q[s] <= '0;
		end else if (wr) begin
			if (idx == CFG_COUNT) count_q <= pwdata[2:0];
			for (int s = 0; s < MAX_SPHERES; s++)
				if (idx == CFG_SPH0 + 3'(s)) sph_q[s] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == CFG_COUNT) prdata = {61'd0, count_q};
		for (int s = 0; s < MAX_SPHERES; s++)
			if (idx == CFG_SPH0 + 3'(s)) prdata = sph_q[s];
	end

	// ray state
	logic signed [31:0] o_q [3];
	logic signed [15:0] d_q [3];
	logic [2:0]         k_q, n_q;
	logic [1:0]         j_q;
	logic               have_q, dark_q, fneg_q;
	logic [25:0]        bt_q, t_q;
	logic [2:0]         obj_q;
	logic signed [31:0] pt_q [3];
	logic signed [15:0] nm_q [3];
	logic signed [24:0] c_q [3];
	logic [23:0]        r_q;
	logic signed [27:0] l_q [3];
	logic signed [63:0] acc_q;
	logic signed [31:0] tca_q;
	logic signed [31:0] v_q [3];
	logic signed [33:0] pu_q [3];
	logic               out_valid_q;
	hit_t               out_q;

	// shared units
	logic        sq_start, sq_busy, dv_start, dv_busy;
	logic [63:0] sq_in;
	logic [31:0] sq_root;
	logic [47:0] dv_num, dv_quot;
	logic [31:0] dv_den;

	rsch_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.busy(sq_busy), .root(sq_root)
	);

	rsch_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .quot(dv_quot)
	);

	// sphere fetch
	logic [63:0]        sph;
	logic signed [24:0] c_w [3];
	logic signed [33:0] l_w [3];
	logic               far_w;

	always_comb begin
		sph   = sph_q[k_q[SW-1:0]];
		far_w = 1'b0;
		for (int i = 0; i < 3; i++) begin
			c_w[i] = {sph[16*i+15], sph[16*i +: 16], 8'd0};
			l_w[i] = 34'(c_w[i]) - 34'(o_q[i]);
			if (l_w[i] >= 34'sd134217728 || l_w[i] <= -34'sd134217728) far_w = 1'b1;
		end
	end

	// shared multiplier
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod, prod_sh;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_DOT: begin
				ma = 32'(l_q[j_q]);
				mb = 32'(d_q[j_q]);
			end
			ST_LL: begin
				ma = 32'(l_q[j_q]);
				mb = 32'(l_q[j_q]);
			end
			ST_TSQ: begin
				ma = tca_q;
				mb = tca_q;
			end
			ST_RSQ: begin
				ma = {8'd0, r_q};
				mb = {8'd0, r_q};
			end
			ST_PNT, ST_FPNT: begin
				ma = 32'(d_q[j_q]);
				mb = {6'd0, t_q};
			end
			ST_VLEN: begin
				ma = v_q[j_q];
				mb = v_q[j_q];
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod    = ma * mb;
	assign prod_sh = prod >>> 14;

	// per-state arithmetic
	logic signed [63:0] rad_w, macc_w;
	logic               skip_r;
	logic signed [33:0] tca34, thc34, t1_w, t_w, p_w, v_w;
	logic               t_bad;
	logic [31:0]        av_w;
	logic [15:0]        qmag;
	logic signed [33:0] numv;
	logic [33:0]        an_w;
	logic [16:0]        ady_w;
	logic               f_ok, in_bounds;
	logic [33:0]        xs_w, zs_w;

	always_comb begin
		macc_w = ((j_q == 2'd0) ? 64'sd0 : acc_q) + prod;
		rad_w  = prod - acc_q;
		skip_r = acc_q > prod;
		tca34  = 34'(tca_q);
		thc34  = {2'b00, sq_root};
		t1_w   = tca34 - thc34;
		t_w    = (t1_w < 0) ? tca34 + thc34 : t1_w;
		t_bad  = (t_w < 0) || (t_w >= $signed({8'd0, LIMIT_Q16}))
			|| (have_q && !(t_w[25:0] < bt_q));
		p_w    = 34'(o_q[j_q]) + prod_sh[33:0];
		v_w    = p_w - 34'(c_q[j_q]);
		av_w   = v_q[j_q][31] ? 32'(-v_q[j_q]) : 32'(v_q[j_q]);
		qmag   = (dv_quot > 48'(UNIT_Q14)) ? UNIT_Q14 : dv_quot[15:0];
		numv   = -(34'(o_q[1]) + 34'sd262144);
		an_w   = numv[33] ? 34'(-numv) : 34'(numv);
		ady_w  = d_q[1][15] ? 17'(-{d_q[1][15], d_q[1]}) : 17'({d_q[1][15], d_q[1]});
		f_ok   = (dv_quot != 48'd0) && !fneg_q && (dv_quot < 48'(LIMIT_Q16))
			&& (!have_q || dv_quot < 48'(bt_q));
		in_bounds = (pu_q[0] < 34'sd655360) && (pu_q[0] > -34'sd655360)
			&& (pu_q[2] < -34'sd655360) && (pu_q[2] > -34'sd1966080);
		// checker parity from bit 17 of the shifted x and the negated z coordinates
		xs_w   = pu_q[0] + 34'sd1310720;
		zs_w   = -pu_q[2];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SLOAD;
			ST_SLOAD: begin
				if (k_q >= n_q) state_d = ST_FLOOR;
				else if (far_w) state_d = ST_NEXT;
				else state_d = ST_DOT;
			end
			ST_DOT:    if (j_q == 2'd2) state_d = ST_LL;
			ST_LL:     if (j_q == 2'd2) state_d = ST_TSQ;
			ST_TSQ:    state_d = ST_RSQ;
			ST_RSQ:    state_d = skip_r ? ST_NEXT : ST_SQ1;
			ST_SQ1:    if (!sq_busy) state_d = ST_TSEL;
			ST_TSEL:   state_d = t_bad ? ST_NEXT : ST_PNT;
			ST_PNT:    if (j_q == 2'd2) state_d = ST_VLEN;
			ST_VLEN:   if (j_q == 2'd2) state_d = ST_LSTART;
			ST_LSTART: state_d = ST_LWAIT;
			ST_LWAIT:  if (!sq_busy) state_d = ST_NSTART;
			ST_NSTART: state_d = (sq_root == 32'd0) ? ST_NEXT : ST_NWAIT;
			ST_NWAIT: begin
				if (!dv_busy) state_d = (j_q == 2'd2) ? ST_NEXT : ST_NSTART;
			end
			ST_NEXT:   state_d = ST_SLOAD;
			ST_FLOOR:  state_d = (d_q[1] == 16'sd0) ? ST_DONE : ST_FWAIT;
			ST_FWAIT:  if (!dv_busy) state_d = ST_FCHK;
			ST_FCHK:   state_d = f_ok ? ST_FPNT : ST_DONE;
			ST_FPNT:   if (j_q == 2'd2) state_d = ST_FEND;
			ST_FEND:   state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// unit control
	always_comb begin
		in_ready = state_q == ST_IDLE;
		sq_start = 1'b0;
		sq_in    = acc_q;
		dv_start = 1'b0;
		dv_num   = {2'd0, av_w, 14'd0};
		dv_den   = sq_root;
		case (state_q)
			ST_RSQ: begin
				sq_start = !skip_r;
				sq_in    = rad_w;
			end
			ST_LSTART: sq_start = 1'b1;
			ST_NSTART: dv_start = sq_root != 32'd0;
			ST_FLOOR: begin
				dv_start = d_q[1] != 16'sd0;
				dv_num   = {an_w[33:0], 14'd0};
				dv_den   = {16'd0, ady_w[15:0]};
			end
			default: begin
				sq_start = 1'b0;
				dv_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					o_q[0] <= in_data.origin_x;
					o_q[1] <= in_data.origin_y;
					o_q[2] <= in_data.origin_z;
					d_q[0] <= in_data.dir_x;
					d_q[1] <= in_data.dir_y;
					d_q[2] <= in_data.dir_z;
					k_q    <= '0;
					j_q    <= '0;
					n_q    <= (count_q > 3'(MAX_SPHERES)) ? 3'(MAX_SPHERES) : count_q;
					have_q <= 1'b0;
					bt_q   <= '0;
					obj_q  <= '0;
					dark_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						pt_q[i] <= '0;
						nm_q[i] <= '0;
					end
				end
			end
			ST_SLOAD: begin
				r_q <= {sph[63:48], 8'd0};
				for (int i = 0; i < 3; i++) begin
					c_q[i] <= c_w[i];
					l_q[i] <= l_w[i][27:0];
				end
				j_q <= '0;
			end
			ST_DOT, ST_LL, ST_VLEN: begin
				if (state_q == ST_LL && j_q == 2'd0) tca_q <= 32'(acc_q >>> 14);
				acc_q <= macc_w;
				j_q   <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
			end
			ST_TSQ: acc_q <= acc_q - prod;
			ST_TSEL: begin
				if (!t_bad) begin
					t_q    <= t_w[25:0];
					have_q <= 1'b1;
					bt_q   <= t_w[25:0];
					obj_q  <= k_q;
					dark_q <= 1'b0;
				end
				j_q <= '0;
			end
			ST_PNT: begin
				pt_q[j_q] <= p_w[31:0];
				v_q[j_q]  <= v_w[31:0];
				j_q       <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
			end
			ST_NSTART: begin
				// zero-length offset from the center gives a zero normal
				if (sq_root == 32'd0)
					for (int i = 0; i < 3; i++) nm_q[i] <= '0;
			end
			ST_NWAIT: begin
				if (!dv_busy) begin
					nm_q[j_q] <= v_q[j_q][31] ? -$signed(qmag) : $signed(qmag);
					j_q       <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
				end
			end
			ST_NEXT: k_q <= k_q + 3'd1;
			ST_FLOOR: begin
				fneg_q <= numv[33] ^ d_q[1][15];
				j_q    <= '0;
			end
			ST_FCHK: t_q <= dv_quot[25:0];
			ST_FPNT: begin
				pu_q[j_q] <= p_w;
				j_q       <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
			end
			ST_FEND: begin
				if (in_bounds) begin
					have_q <= 1'b1;
					bt_q   <= t_q;
					obj_q  <= FLOOR_ID;
					dark_q <= xs_w[17] ^ zs_w[17];
					for (int i = 0; i < 3; i++) pt_q[i] <= pu_q[i][31:0];
					nm_q[0] <= '0;
					nm_q[1] <= $signed(UNIT_Q14);
					nm_q[2] <= '0;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					if (have_q) begin
						out_q.hit          <= 1'b1;
						out_q.object_id    <= obj_q;
						out_q.checker_dark <= dark_q;
						out_q.distance     <= bt_q;
						out_q.point_x      <= pt_q[0];
						out_q.point_y      <= pt_q[1];
						out_q.point_z      <= pt_q[2];
						out_q.normal_x     <= nm_q[0];
						out_q.normal_y     <= nm_q[1];
						out_q.normal_z     <= nm_q[2];
					end else begin
						out_q <= '0;
					end
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.distance == 26'd0
			&& out_data.object_id == 3'd0 && !out_data.checker_dark)
		else $error("miss beat carries nonzero fields");

	a_sphere_light: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit && out_data.object_id != FLOOR_ID
			|-> !out_data.checker_dark)
		else $error("sphere hit with checker parity set");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.distance < LIMIT_Q16)
		else $error("hit beyond range limit");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_busy && dv_busy))
		else $error("square root and divider busy together");

endmodule

### dv/ray_scene_closest_hit_core_tb.sv
// testbench for the ray closest-hit core: directed and random rays against configured scenes
`timescale 1ns / 1ps
module ray_scene_closest_hit_core_tb;
	import rsch_pkg::*;

	localparam longint ONE = 65536;
	localparam longint RANGE_END = 1000 * ONE;
	localparam longint FAR_LIM = 2048 * ONE;
	localparam int SETTLE = 1200;
	localparam int STALL_LIMIT = 20000;
	localparam logic [2:0] CFG_BAD = 3'd5;

	class hit_scoreboard;
		hit_t pending_hits[$];
		logic [63:0] sphere_reg[4];
		logic [2:0] count;
		int errors;

		function new();
			count = 0;
			errors = 0;
			foreach (sphere_reg[i]) sphere_reg[i] = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			if (idx == CFG_COUNT) count = val[2:0];
			else if (idx >= CFG_SPH0 && idx <= CFG_SPH0 + 3) sphere_reg[idx - CFG_SPH0] = val;
		endfunction

		function longint int_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return longint'(res);
		endfunction

		function void note_ray(ray_t r);
			longint o[3], d[3], c[3], lv[3], v[3], p[3], pt[3], nm[3];
			longint rad, dot, ll, tca, d2, r2, thc, t, len2, len, best, num, dd, q, xi, zi;
			bit found, far_away;
			logic [2:0] obj;
			logic dark;
			int n;
			hit_t h;
			o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
			d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
			found = 0; best = 0; obj = 0; dark = 0;
			for (int i = 0; i < 3; i++) begin
				pt[i] = 0;
				nm[i] = 0;
			end
			n = (count > 4) ? 4 : count;
			for (int k = 0; k < n; k++) begin
				rad = longint'(sphere_reg[k][63:48]) * 256;
				far_away = 0;
				dot = 0;
				ll = 0;
				for (int i = 0; i < 3; i++) begin
					c[i] = longint'($signed(sphere_reg[k][16*i +: 16])) * 256;
					lv[i] = c[i] - o[i];
					if (lv[i] >= FAR_LIM || lv[i] <= -FAR_LIM) far_away = 1;
				end
				if (far_away) continue;
				for (int i = 0; i < 3; i++) begin
					dot += lv[i] * d[i];
					ll += lv[i] * lv[i];
				end
				tca = dot >>> 14;
				d2 = ll - tca * tca;
				r2 = rad * rad;
				if (d2 > r2) continue;
				thc = int_sqrt(r2 - d2);
				t = tca - thc;
				if (t < 0) t = tca + thc;
				if (t < 0 || t >= RANGE_END) continue;
				if (found && !(t < best)) continue;
				found = 1;
				best = t;
				obj = k[2:0];
				dark = 0;
				len2 = 0;
				for (int i = 0; i < 3; i++) begin
					pt[i] = o[i] + ((d[i] * t) >>> 14);
					v[i] = pt[i] - c[i];
					len2 += v[i] * v[i];
				end
				len = int_sqrt(len2);
				for (int i = 0; i < 3; i++) begin
					q = 0;
					if (len != 0) begin
						q = v[i] * 16384 / len;
						if (q > 16384) q = 16384;
						if (q < -16384) q = -16384;
					end
					nm[i] = q;
				end
			end
			if (d[1] != 0) begin
				num = -(o[1] + 4 * ONE);
				dd = num * 16384 / d[1];
				if (dd > 0 && dd < RANGE_END && (!found || dd < best)) begin
					for (int i = 0; i < 3; i++) p[i] = o[i] + ((d[i] * dd) >>> 14);
					// bounds use the unwrapped point
					if (p[0] < 10 * ONE && p[0] > -10 * ONE && p[2] < -10 * ONE && p[2] > -30 * ONE) begin
						xi = (p[0] + 20 * ONE) / (2 * ONE);
						zi = p[2] / (2 * ONE);
						found = 1;
						best = dd;
						obj = FLOOR_ID;
						dark = xi[0] ^ zi[0];
						for (int i = 0; i < 3; i++) pt[i] = p[i];
						nm[0] = 0;
						nm[1] = 16384;
						nm[2] = 0;
					end
				end
			end
			h = '0;
			if (found) begin
				h.hit = 1;
				h.object_id = obj;
				h.checker_dark = dark;
				h.distance = best[25:0];
				h.point_x = pt[0][31:0];
				h.point_y = pt[1][31:0];
				h.point_z = pt[2][31:0];
				h.normal_x = nm[0][15:0];
				h.normal_y = nm[1][15:0];
				h.normal_z = nm[2][15:0];
			end
			pending_hits.insert(pending_hits.size(), h);
		endfunction

		function void report(string fname, logic [63:0] e, logic [63:0] a);
			errors++;
			if (errors <= 60)
				$display("%0t: %s expected %0h got %0h", $realtime, fname, e, a);
		endfunction

		function void check_hit(hit_t a);
			hit_t e;
			if (pending_hits.size() == 0) begin
				report("unexpected beat", 64'd0, 64'(a.distance));
				return;
			end
			e = pending_hits.pop_front();
			if (a.hit !== e.hit) report("hit", 64'(e.hit), 64'(a.hit));
			if (a.object_id !== e.object_id)
				report("object_id", 64'(e.object_id), 64'(a.object_id));
			if (a.checker_dark !== e.checker_dark)
				report("checker_dark", 64'(e.checker_dark), 64'(a.checker_dark));
			if (a.distance !== e.distance)
				report("distance", 64'(e.distance), 64'(a.distance));
			if (a.point_x !== e.point_x) report("point_x", 64'(e.point_x), 64'(a.point_x));
			if (a.point_y !== e.point_y) report("point_y", 64'(e.point_y), 64'(a.point_y));
			if (a.point_z !== e.point_z) report("point_z", 64'(e.point_z), 64'(a.point_z));
			if (a.normal_x !== e.normal_x)
				report("normal_x", 64'(e.normal_x), 64'(a.normal_x));
			if (a.normal_y !== e.normal_y)
				report("normal_y", 64'(e.normal_y), 64'(a.normal_y));
			if (a.normal_z !== e.normal_z)
				report("normal_z", 64'(e.normal_z), 64'(a.normal_z));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	ray_t in_data;
	hit_t out_data;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;

	hit_scoreboard sb;
	bit quiet;
	int idle_cycles;

	ray_scene_closest_hit_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready = quiet ? 1'b1 : ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_hit(out_data);
	end

	// watchdog on cycles with no beat on either channel and no config access
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] val);
		psel = 1; penable = 0; pwrite = 1; paddr = {idx, 3'b000}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic drain();
		while (sb.pending_hits.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_ray(ray_t r);
		while (!quiet && $urandom_range(99) < 28) @(negedge clk);
		in_valid = 1;
		in_data = r;
		do @(posedge clk); while (!in_ready);
		sb.note_ray(r);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic ray_t aim(longint ox, longint oy, longint oz, real tx, real ty, real tz);
		ray_t r;
		real dx, dy, dz, m;
		dx = tx - $itor(ox) / 65536.0;
		dy = ty - $itor(oy) / 65536.0;
		dz = tz - $itor(oz) / 65536.0;
		m = $sqrt(dx * dx + dy * dy + dz * dz);
		if (m == 0.0) begin
			dz = -1.0;
			m = 1.0;
		end
		r.origin_x = ox[31:0];
		r.origin_y = oy[31:0];
		r.origin_z = oz[31:0];
		r.dir_x = 16'($rtoi(dx / m * 16383.0));
		r.dir_y = 16'($rtoi(dy / m * 16383.0));
		r.dir_z = 16'($rtoi(dz / m * 16383.0));
		return r;
	endfunction

	function automatic ray_t raw_ray(longint ox, longint oy, longint oz, int dx, int dy, int dz);
		ray_t r;
		r.origin_x = ox[31:0];
		r.origin_y = oy[31:0];
		r.origin_z = oz[31:0];
		r.dir_x = 16'(dx);
		r.dir_y = 16'(dy);
		r.dir_z = 16'(dz);
		return r;
	endfunction

	function automatic real rnd(real lo, real hi);
		return lo + (hi - lo) * $itor($urandom_range(10000)) / 10000.0;
	endfunction

	function automatic logic [63:0] pack_sphere(real x, real y, real z, real rad);
		return {16'($rtoi(rad * 256.0)), 16'($rtoi(z * 256.0)), 16'($rtoi(y * 256.0)),
			16'($rtoi(x * 256.0))};
	endfunction

	function automatic logic [63:0] rand_sphere();
		return pack_sphere(rnd(-8, 8), rnd(-3, 4), rnd(-25, -5), rnd(0.5, 4));
	endfunction

	function automatic ray_t rand_ray();
		int sel, k;
		longint ox, oy, oz;
		logic [63:0] s;
		sel = $urandom_range(99);
		ox = longint'($rtoi(rnd(-3, 3) * 65536.0));
		oy = longint'($rtoi(rnd(-3, 3) * 65536.0));
		oz = longint'($rtoi(rnd(-3, 3) * 65536.0));
		if (sel < 45) begin
			k = $urandom_range(3);
			s = sb.sphere_reg[k];
			return aim(ox, oy, oz,
				$itor($signed(s[15:0])) / 256.0 + rnd(-2, 2),
				$itor($signed(s[31:16])) / 256.0 + rnd(-2, 2),
				$itor($signed(s[47:32])) / 256.0 + rnd(-2, 2));
		end else if (sel < 75) begin
			return aim(ox, oy, oz, rnd(-12, 12), -4.0, rnd(-32, -8));
		end else if (sel < 88) begin
			return raw_ray(ox, oy, oz, int'($urandom_range(32768)) - 16384,
				int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384);
		end
		return raw_ray(longint'($signed($urandom)), longint'($signed($urandom)),
			longint'($signed($urandom)), int'($urandom_range(32768)) - 16384,
			int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384);
	endfunction

	task automatic random_rays(int n);
		for (int i = 0; i < n; i++) begin
			quiet = (i >= n / 3 && i < n / 3 + 40);
			send_ray(rand_ray());
		end
		quiet = 0;
	endtask

	initial begin
		sb = new();
		quiet = 0;
		idle_cycles = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		arst_n = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		reg_write(CFG_COUNT, 64'd4);
		reg_write(CFG_SPH0, pack_sphere(0, 0, -15, 2));
		reg_write(3'(CFG_SPH0 + 1), pack_sphere(3, 1, -12, 1));
		reg_write(3'(CFG_SPH0 + 2), pack_sphere(-4, 0, -20, 3));
		// zero radius sphere for the degenerate normal
		reg_write(3'(CFG_SPH0 + 3), pack_sphere(5, 5, 5, 0));
		reg_write(CFG_BAD, 64'hFFFF_FFFF_FFFF_FFFF);

		send_ray(raw_ray(0, 0, 0, 0, 0, -16384));
		send_ray(raw_ray(0, 0, -20 * ONE, 0, -16384, 0));
		send_ray(raw_ray(0, 0, -15 * ONE, 0, 0, -16384));
		send_ray(raw_ray(0, 0, -15 * ONE, 16384, 0, 0));
		send_ray(raw_ray(5 * ONE, 5 * ONE, 5 * ONE, 0, 0, 16384));
		send_ray(raw_ray(0, 0, 0, 0, 0, 0));
		send_ray(raw_ray(0, 0, 0, 16384, 0, 0));
		send_ray(raw_ray(0, 0, 0, 0, 16384, 0));
		send_ray(raw_ray(0, 5 * ONE, -20 * ONE, 0, -1, 0));
		send_ray(raw_ray(-2147483648, -2147483648, -2147483648, 16384, 16384, 16384));
		send_ray(raw_ray(2147483647, 2147483647, 2147483647, -16384, -16384, -16384));
		send_ray(raw_ray(2147483647, -2147483648, 0, -16384, 16384, -16384));
		send_ray(raw_ray(0, -4 * ONE, -20 * ONE, 0, -16384, 0));
		send_ray(raw_ray(0, 0, 0, 0, -9000, -13000));
		send_ray(raw_ray(3 * ONE, 1 * ONE, 0, 0, 0, -16384));
		send_ray(aim(0, 0, 0, 9.99, -4.0, -10.01));
		send_ray(aim(0, 0, 0, -9.5, -4.0, -29.5));
		send_ray(aim(0, 0, 0, 0.0, -4.0, -40.0));
		drain();

		reg_write(CFG_COUNT, 64'd0);
		random_rays(120);
		drain();

		reg_write(CFG_COUNT, 64'd7);
		for (int k = 0; k < 4; k++) reg_write(3'(CFG_SPH0 + k), rand_sphere());
		random_rays(250);
		// hold the sender until the core has caught up
		while (sb.pending_hits.size() != 0) @(negedge clk);
		random_rays(100);
		drain();

		reg_write(CFG_COUNT, 64'd4);
		reg_write(CFG_SPH0, 64'hFFFF_7FFF_7FFF_7FFF);
		reg_write(3'(CFG_SPH0 + 1), 64'hFFFF_8000_8000_8000);
		reg_write(3'(CFG_SPH0 + 2), pack_sphere(0, 0, -20, 255));
		reg_write(3'(CFG_SPH0 + 3), 64'h0000_0000_0000_0000);
		random_rays(100);
		drain();

		reg_write(CFG_COUNT, 64'd2);
		for (int k = 0; k < 4; k++) reg_write(3'(CFG_SPH0 + k), rand_sphere());
		random_rays(200);
		drain();

		reg_write(CFG_COUNT, 64'd1);
		reg_write(CFG_SPH0, rand_sphere());
		random_rays(180);
		drain();

		if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
